// File: hw/rtl/brfmu_pkg.sv
// ----------------------------------------------------------------------------
// brfmu_pkg
// Shared types, codes and the helper function of the banked register file unit.
// ----------------------------------------------------------------------------
`default_nettype none
package brfmu_pkg;

  typedef enum logic [2:0] {
    FN_RD_USR  = 3'd0,
    FN_WR_USR  = 3'd1,
    FN_WR_CPSR = 3'd2,
    FN_RD_SPSR = 3'd3,
    FN_WR_SPSR = 3'd4,
    FN_EXC     = 3'd5,
    FN_RET     = 3'd6,
    FN_NZCV    = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_MODE  = 3'd1,
    ERR_SPSR  = 3'd2,
    ERR_STATE = 3'd3,
    ERR_ENDN  = 3'd4,
    ERR_THUMB = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    CFG_CTRL  = 2'd0,
    CFG_LEVEL = 2'd1,
    CFG_THUMB = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  localparam logic [4:0]  MODE_USR = 5'h10;
  localparam logic [4:0]  MODE_FIQ = 5'h11;
  localparam logic [4:0]  MODE_IRQ = 5'h12;
  localparam logic [4:0]  MODE_SVC = 5'h13;
  localparam logic [4:0]  MODE_ABT = 5'h17;
  localparam logic [4:0]  MODE_UND = 5'h1B;
  localparam logic [4:0]  MODE_SYS = 5'h1F;
  localparam logic [31:0] CPSR_RESET = 32'h0000_01D3;
  localparam logic [31:0] IT_BITS = 32'h0600_FC00;
  localparam logic [31:0] RET_MASK = 32'hFF0F_FFFF;
  localparam logic [31:0] HIVEC_BASE = 32'hFFFF_0000;
  localparam int BIT_T = 5;
  localparam int BIT_F = 6;
  localparam int BIT_I = 7;
  localparam int BIT_A = 8;
  localparam int BIT_E = 9;
  localparam int BIT_J = 24;

  // bank 0..5; valid flag clear for unknown modes
  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
  } bank_t;

  // command from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  function automatic bank_t bank_of(input logic [4:0] m);
    bank_t b;
    b.ok = 1'b1;
    case (m)
      MODE_USR, MODE_SYS: b.idx = 3'd0;
      MODE_FIQ: b.idx = 3'd1;
      MODE_IRQ: b.idx = 3'd2;
      MODE_SVC: b.idx = 3'd3;
      MODE_ABT: b.idx = 3'd4;
      MODE_UND: b.idx = 3'd5;
      default: begin
        b.ok  = 1'b0;
        b.idx = 3'd0;
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/brfmu_ctrl.sv
// ----------------------------------------------------------------------------
// brfmu_ctrl
// Handshake controller: capture, execute, present result.
// ----------------------------------------------------------------------------
`default_nettype none
module brfmu_ctrl (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  out_stall_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output brfmu_pkg::cmd_t cmd_o
);

  brfmu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brfmu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      brfmu_pkg::ST_IDLE: if (in_valid_i) state_d = brfmu_pkg::ST_EXEC;
      brfmu_pkg::ST_EXEC: state_d = brfmu_pkg::ST_OUT;
      brfmu_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = in_valid_i ? brfmu_pkg::ST_EXEC : brfmu_pkg::ST_IDLE;
        end
      end
      default: state_d = brfmu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      brfmu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      brfmu_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      brfmu_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        in_stall_o  = out_stall_i;
        cmd_o.load  = in_valid_i && !out_stall_i;
      end
      default: ;
    endcase
  end

  a_out_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o) else $error("result not presented after execute");
  a_no_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.exec && out_valid_o)) else $error("execute while result held");
  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec) else $error("loaded item not executed");

endmodule
`default_nettype wire

// File: hw/rtl/brfmu_dpath.sv
// ----------------------------------------------------------------------------
// brfmu_dpath
// Register banks, status words and the per-operation update logic.
// ----------------------------------------------------------------------------
`default_nettype none
module brfmu_dpath (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  brfmu_pkg::cmd_t cmd_i,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  input  wire  [2:0]  func_i,
  input  wire  [3:0]  reg_index_i,
  input  wire  [31:0] data_i,
  input  wire  [31:0] user_mask_i,
  input  wire  [31:0] priv_mask_i,
  input  wire  [31:0] state_bits_mask_i,
  input  wire  [31:0] spsr_mask_i,
  input  wire  [2:0]  exc_kind_i,
  output logic [31:0] read_data_o,
  output logic [31:0] status_word_o,
  output logic [31:0] target_pc_o,
  output logic [2:0]  error_code_o
);

  logic [31:0] ctrl_q;
  logic [1:0]  level_q;
  logic        thumb_q;

  logic [31:0] live_q [16];
  logic [31:0] sp_q [6];
  logic [31:0] lr_q [6];
  logic [31:0] fsh_q [5];
  logic [31:0] spsr_q [5];
  logic [31:0] cpsr_q;

  // captured item
  logic [2:0]  func_q, kind_q;
  logic [3:0]  reg_q;
  logic [31:0] data_q, umask_q, pmask_q, smask_q, spmask_q;

  logic [31:0] rd_q, pc_q;
  logic [2:0]  err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      level_q <= 2'd2;
      thumb_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        brfmu_pkg::CFG_CTRL:  ctrl_q  <= cfg_data_i;
        brfmu_pkg::CFG_LEVEL: level_q <= cfg_data_i[1:0];
        brfmu_pkg::CFG_THUMB: thumb_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      reg_q    <= reg_index_i;
      data_q   <= data_i;
      umask_q  <= user_mask_i;
      pmask_q  <= priv_mask_i;
      smask_q  <= state_bits_mask_i;
      spmask_q <= spsr_mask_i;
      kind_q   <= exc_kind_i;
    end
  end

  // ---- execute logic ----
  logic [4:0]      mode;
  brfmu_pkg::bank_t cb;
  logic            in_fiq, has_spsr;
  logic [2:0]      sidx;

  logic [31:0] n_live [16];
  logic [31:0] n_sp [6];
  logic [31:0] n_lr [6];
  logic [31:0] n_fsh [5];
  logic [31:0] n_spsr [5];
  logic [31:0] n_cpsr, rd, pc, m, w, lr, src, vec;
  logic [2:0]  err;
  logic        do_status;
  logic [4:0]  tm, newm;
  logic [31:0] voff;
  brfmu_pkg::bank_t ob, nb, wb, tb;
  logic [2:0]  ri;
  logic        fiq_reg;

  always_comb begin
    mode     = cpsr_q[4:0];
    cb       = brfmu_pkg::bank_of(mode);
    in_fiq   = (mode == brfmu_pkg::MODE_FIQ);
    has_spsr = cb.ok && (cb.idx != 3'd0);
    sidx     = cb.idx - 3'd1;
    n_live = live_q;
    n_sp   = sp_q;
    n_lr   = lr_q;
    n_fsh  = fsh_q;
    n_spsr = spsr_q;
    n_cpsr = cpsr_q;
    rd = '0;
    pc = '0;
    err = brfmu_pkg::ERR_OK;
    m = '0;
    w = '0;
    lr = '0;
    src = '0;
    vec = '0;
    voff = '0;
    tm = brfmu_pkg::MODE_UND;
    newm = mode;
    do_status = 1'b0;
    fiq_reg = (reg_q >= 4'd8) && (reg_q <= 4'd12) && in_fiq;
    ri = 3'(reg_q - 4'd8);
    case (brfmu_pkg::func_e'(func_q))
      brfmu_pkg::FN_RD_USR: begin
        if (fiq_reg) rd = fsh_q[ri];
        else if (reg_q == 4'd13) rd = (cb.idx == 3'd0 && cb.ok) ? live_q[13] : sp_q[0];
        else if (reg_q == 4'd14) rd = (cb.idx == 3'd0 && cb.ok) ? live_q[14] : lr_q[0];
        else rd = live_q[reg_q];
      end
      brfmu_pkg::FN_WR_USR: begin
        if (fiq_reg) n_fsh[ri] = data_q;
        else if (reg_q == 4'd13) begin
          if (cb.idx == 3'd0 && cb.ok) n_live[13] = data_q;
          else n_sp[0] = data_q;
        end else if (reg_q == 4'd14) begin
          if (cb.idx == 3'd0 && cb.ok) n_live[14] = data_q;
          else n_lr[0] = data_q;
        end else n_live[reg_q] = data_q;
      end
      brfmu_pkg::FN_WR_CPSR: begin
        if ((mode != brfmu_pkg::MODE_USR) && ((data_q & smask_q) != '0)) begin
          err = brfmu_pkg::ERR_STATE;
        end else begin
          m = (mode != brfmu_pkg::MODE_USR) ? pmask_q : umask_q;
          if (ctrl_q[27] && data_q[brfmu_pkg::BIT_F]) m[brfmu_pkg::BIT_F] = 1'b0;
          w = (cpsr_q & ~m) | (data_q & m);
          do_status = 1'b1;
        end
      end
      brfmu_pkg::FN_RD_SPSR: begin
        if (!has_spsr) err = brfmu_pkg::ERR_SPSR;
        else rd = spsr_q[sidx];
      end
      brfmu_pkg::FN_WR_SPSR: begin
        if (!has_spsr) err = brfmu_pkg::ERR_SPSR;
        else n_spsr[sidx] = (spsr_q[sidx] & ~spmask_q) | (data_q & spmask_q);
      end
      brfmu_pkg::FN_EXC: begin
        if (kind_q > 3'd4) begin
          err = brfmu_pkg::ERR_MODE;
        end else begin
          case (kind_q)
            3'd0: begin tm = brfmu_pkg::MODE_UND; voff = 32'd4;  end
            3'd1: begin tm = brfmu_pkg::MODE_SVC; voff = 32'd8;  end
            3'd2: begin tm = brfmu_pkg::MODE_ABT; voff = 32'd12; end
            3'd3: begin tm = brfmu_pkg::MODE_IRQ; voff = 32'd24; end
            default: begin tm = brfmu_pkg::MODE_ABT; voff = 32'd16; end
          endcase
          if (cpsr_q[brfmu_pkg::BIT_T]) begin
            lr = data_q + 32'd4 + ((kind_q == 3'd4) ? 32'd4 : 32'd0)
                 - ((kind_q < 3'd2) ? 32'd2 : 32'd0);
          end else begin
            lr = data_q + 32'd8 - ((kind_q == 3'd4) ? 32'd0 : 32'd4);
          end
          newm = tm;
          n_cpsr = {cpsr_q[31:5], tm};
          n_cpsr[brfmu_pkg::BIT_I] = 1'b1;
          n_cpsr = n_cpsr & ~(brfmu_pkg::IT_BITS | (32'd1 << brfmu_pkg::BIT_J)
                   | (32'd1 << brfmu_pkg::BIT_T) | (32'd1 << brfmu_pkg::BIT_E));
          if (kind_q >= 3'd2) n_cpsr[brfmu_pkg::BIT_A] = 1'b1;
          if (level_q >= 2'd2 && ctrl_q[30]) n_cpsr[brfmu_pkg::BIT_T] = 1'b1;
          if (level_q >= 2'd1 && ctrl_q[25]) n_cpsr[brfmu_pkg::BIT_E] = 1'b1;
          vec = ctrl_q[13] ? brfmu_pkg::HIVEC_BASE : 32'd0;
          pc  = vec + voff;
        end
      end
      brfmu_pkg::FN_RET: begin
        if (!has_spsr) begin
          err = brfmu_pkg::ERR_SPSR;
        end else begin
          src = spsr_q[sidx];
          w = src;
          if (level_q >= 2'd2) begin
            m = brfmu_pkg::RET_MASK;
            if (ctrl_q[27] && src[brfmu_pkg::BIT_F]) m[brfmu_pkg::BIT_F] = 1'b0;
            w = (cpsr_q & ~m) | (src & m);
          end
          do_status = 1'b1;
          pc = w[brfmu_pkg::BIT_T] ? {data_q[31:1], 1'b0} : {data_q[31:2], 2'b00};
        end
      end
      default: n_cpsr = {data_q[31:28], cpsr_q[27:0]};
    endcase

    wb = brfmu_pkg::bank_of(w[4:0]);
    tb = brfmu_pkg::bank_of(tm);

    if (do_status) begin
      if (w[brfmu_pkg::BIT_E]) err = brfmu_pkg::ERR_ENDN;
      else if (w[brfmu_pkg::BIT_T] && !thumb_q) err = brfmu_pkg::ERR_THUMB;
      else if (!wb.ok) err = brfmu_pkg::ERR_MODE;
      else begin
        n_cpsr = w;
        newm = w[4:0];
      end
    end

    // bank switch from the old mode to the new one
    ob = cb;
    nb = brfmu_pkg::bank_of(newm);
    if (err == brfmu_pkg::ERR_OK && ob.ok && nb.ok && ob.idx != nb.idx) begin
      n_sp[ob.idx] = n_live[13];
      n_live[13]   = sp_q[nb.idx];
      n_lr[ob.idx] = n_live[14];
      n_live[14]   = lr_q[nb.idx];
      if ((ob.idx == 3'd1) != (nb.idx == 3'd1)) begin
        for (int i = 0; i < 5; i++) begin
          n_live[8+i] = fsh_q[i];
          n_fsh[i]    = live_q[8+i];
        end
      end
    end

    if (func_q == brfmu_pkg::FN_EXC && err == brfmu_pkg::ERR_OK) begin
      n_spsr[3'(tb.idx - 3'd1)] = cpsr_q;
      n_live[14] = lr;
      n_live[15] = pc;
    end

    if (err != brfmu_pkg::ERR_OK) begin
      rd = '0;
      pc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) live_q[i] <= '0;
      for (int i = 0; i < 6; i++) begin
        sp_q[i] <= '0;
        lr_q[i] <= '0;
      end
      for (int i = 0; i < 5; i++) begin
        fsh_q[i]  <= '0;
        spsr_q[i] <= '0;
      end
      cpsr_q <= brfmu_pkg::CPSR_RESET;
    end else if (cmd_i.exec && err == brfmu_pkg::ERR_OK) begin
      live_q <= n_live;
      sp_q   <= n_sp;
      lr_q   <= n_lr;
      fsh_q  <= n_fsh;
      spsr_q <= n_spsr;
      cpsr_q <= n_cpsr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q  <= rd;
      pc_q  <= pc;
      err_q <= err;
    end
  end

  assign read_data_o   = rd_q;
  assign status_word_o = cpsr_q;
  assign target_pc_o   = pc_q;
  assign error_code_o  = err_q;

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && err != brfmu_pkg::ERR_OK) |=> $stable(cpsr_q))
    else $error("status changed on error");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && err != brfmu_pkg::ERR_OK) |=> (rd_q == '0 && pc_q == '0))
    else $error("error result not cleared");
  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(cpsr_q)) else $error("status changed while idle");

endmodule
`default_nettype wire

// File: hw/rtl/banked_register_file_mode_unit.sv
// Flow: an accepted item is captured, then executed; the result is registered and held
// until taken. A new item is taken only while idle or while the last result is handed
// over without a stall; the single execute step of the controller is never overlapped.
// Reset: asynchronous active low; the banked registers clear to zero, status word to
// supervisor mode with I, F and A set; configuration to its defaults.
// ----------------------------------------------------------------------------
// banked_register_file_mode_unit
// Banked register file with mode switching and exception entry and return.
// ----------------------------------------------------------------------------
`default_nettype none
module banked_register_file_mode_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  func_i,
  input  wire  [3:0]  reg_index_i,
  input  wire  [31:0] data_i,
  input  wire  [31:0] user_mask_i,
  input  wire  [31:0] priv_mask_i,
  input  wire  [31:0] state_bits_mask_i,
  input  wire  [31:0] spsr_mask_i,
  input  wire  [2:0]  exc_kind_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] read_data_o,
  output logic [31:0] status_word_o,
  output logic [31:0] target_pc_o,
  output logic [2:0]  error_code_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);

  brfmu_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  brfmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  brfmu_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .func_i            (func_i),
    .reg_index_i       (reg_index_i),
    .data_i            (data_i),
    .user_mask_i       (user_mask_i),
    .priv_mask_i       (priv_mask_i),
    .state_bits_mask_i (state_bits_mask_i),
    .spsr_mask_i       (spsr_mask_i),
    .exc_kind_i        (exc_kind_i),
    .read_data_o       (read_data_o),
    .status_word_o     (status_word_o),
    .target_pc_o       (target_pc_o),
    .error_code_o      (error_code_o)
  );

endmodule
`default_nettype wire

// File: dv/banked_register_file_mode_unit_test.sv
// ----------------------------------------------------------------------------
// banked_register_file_mode_unit_test
// Self-checking bench for the banked register file: a predictor tracks
// registers, banks, saved and current status; results are checked per field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module banked_register_file_mode_unit_test;
  import brfmu_pkg::*;

  typedef struct packed {
    logic [31:0] rd;
    logic [31:0] status;
    logic [31:0] pc;
    logic [2:0]  err;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [3:0]  reg_index_i = '0;
  logic [31:0] data_i = '0;
  logic [31:0] user_mask_i = '0;
  logic [31:0] priv_mask_i = '0;
  logic [31:0] state_bits_mask_i = '0;
  logic [31:0] spsr_mask_i = '0;
  logic [2:0]  exc_kind_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic [31:0] status_word_o;
  logic [31:0] target_pc_o;
  logic [2:0]  error_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  banked_register_file_mode_unit dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] m_ctrl;
  logic [1:0]  m_level;
  logic        m_thumb;
  logic [31:0] m_regs [16];
  logic [31:0] m_sp [6];
  logic [31:0] m_lr [6];
  logic [31:0] m_fiq [5];
  logic [31:0] m_spsr [5];
  logic [31:0] m_cpsr;

  outcome_t expected_q [$];
  int       mismatches = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  bit       hold_recv = 1'b0;

  function automatic int bank_idx(input logic [4:0] m);
    case (m)
      MODE_USR, MODE_SYS: return 0;
      MODE_FIQ: return 1;
      MODE_IRQ: return 2;
      MODE_SVC: return 3;
      MODE_ABT: return 4;
      MODE_UND: return 5;
      default: return -1;
    endcase
  endfunction

  task automatic swap_banks(input logic [4:0] om, input logic [4:0] nm);
    int ob, nb;
    logic [31:0] t;
    ob = bank_idx(om);
    nb = bank_idx(nm);
    if (ob < 0 || nb < 0 || ob == nb) return;
    m_sp[ob] = m_regs[13];
    m_regs[13] = m_sp[nb];
    m_lr[ob] = m_regs[14];
    m_regs[14] = m_lr[nb];
    if ((ob == 1) != (nb == 1))
      for (int i = 0; i < 5; i++) begin
        t = m_regs[8+i];
        m_regs[8+i] = m_fiq[i];
        m_fiq[i] = t;
      end
  endtask

  task automatic set_status(input logic [31:0] w, output logic [2:0] e);
    logic [4:0] om;
    om = m_cpsr[4:0];
    if (w[BIT_E]) e = ERR_ENDN;
    else if (w[BIT_T] && !m_thumb) e = ERR_THUMB;
    else if (bank_idx(w[4:0]) < 0) e = ERR_MODE;
    else begin
      e = ERR_OK;
      m_cpsr = w;
      swap_banks(om, w[4:0]);
    end
  endtask

  task automatic predict_mode_op(input func_e fn, input logic [3:0] r,
                                 input logic [31:0] d, um, pm, sm, spm,
                                 input logic [2:0] kind);
    outcome_t o;
    logic [4:0] md, tm;
    logic fiq, usrb, priv;
    int s;
    logic [31:0] m, old, lrv, src, merged;
    logic [2:0] e;
    o = '0;
    e = ERR_OK;
    md = m_cpsr[4:0];
    fiq = (md == MODE_FIQ);
    usrb = (bank_idx(md) == 0);
    s = bank_idx(md) >= 1 ? bank_idx(md) - 1 : -1;
    case (fn)
      FN_RD_USR: begin
        if (r >= 8 && r <= 12 && fiq) o.rd = m_fiq[r-8];
        else if (r == 13) o.rd = usrb ? m_regs[13] : m_sp[0];
        else if (r == 14) o.rd = usrb ? m_regs[14] : m_lr[0];
        else o.rd = m_regs[r];
      end
      FN_WR_USR: begin
        if (r >= 8 && r <= 12 && fiq) m_fiq[r-8] = d;
        else if (r == 13) begin
          if (usrb) m_regs[13] = d; else m_sp[0] = d;
        end else if (r == 14) begin
          if (usrb) m_regs[14] = d; else m_lr[0] = d;
        end else m_regs[r] = d;
      end
      FN_WR_CPSR: begin
        priv = (md != MODE_USR);
        if (priv && (d & sm) != 0) e = ERR_STATE;
        else begin
          m = priv ? pm : um;
          if (m_ctrl[27] && d[BIT_F]) m[BIT_F] = 1'b0;
          set_status((m_cpsr & ~m) | (d & m), e);
        end
      end
      FN_RD_SPSR: if (s < 0) e = ERR_SPSR; else o.rd = m_spsr[s];
      FN_WR_SPSR: if (s < 0) e = ERR_SPSR;
                  else m_spsr[s] = (m_spsr[s] & ~spm) | (d & spm);
      FN_EXC: begin
        if (kind > 4) e = ERR_MODE;
        else begin
          old = m_cpsr;
          case (kind)
            0: tm = MODE_UND;
            1: tm = MODE_SVC;
            3: tm = MODE_IRQ;
            default: tm = MODE_ABT;
          endcase
          if (old[BIT_T]) lrv = d + 4 + (kind == 4 ? 4 : 0) - (kind < 2 ? 2 : 0);
          else lrv = d + 8 - (kind == 4 ? 0 : 4);
          m_cpsr[4:0] = tm;
          swap_banks(old[4:0], tm);
          m_spsr[bank_idx(tm)-1] = old;
          m_regs[14] = lrv;
          m_cpsr[BIT_I] = 1'b1;
          m_cpsr &= ~(IT_BITS | (32'd1 << BIT_J) | (32'd1 << BIT_T) | (32'd1 << BIT_E));
          if (kind >= 2) m_cpsr[BIT_A] = 1'b1;
          if (m_level >= 2 && m_ctrl[30]) m_cpsr[BIT_T] = 1'b1;
          if (m_level >= 1 && m_ctrl[25]) m_cpsr[BIT_E] = 1'b1;
          case (kind)
            0: o.pc = 4;
            1: o.pc = 8;
            2: o.pc = 12;
            3: o.pc = 24;
            default: o.pc = 16;
          endcase
          if (m_ctrl[13]) o.pc += HIVEC_BASE;
          m_regs[15] = o.pc;
        end
      end
      FN_RET: begin
        if (s < 0) e = ERR_SPSR;
        else begin
          src = m_spsr[s];
          merged = src;
          if (m_level >= 2) begin
            m = RET_MASK;
            if (m_ctrl[27] && src[BIT_F]) m[BIT_F] = 1'b0;
            merged = (m_cpsr & ~m) | (src & m);
          end
          set_status(merged, e);
          if (e == ERR_OK) o.pc = merged[BIT_T] ? (d & ~32'd1) : (d & ~32'd3);
        end
      end
      default: m_cpsr = {d[31:28], m_cpsr[27:0]};
    endcase
    if (e != ERR_OK) begin
      o.rd = '0;
      o.pc = '0;
    end
    o.status = m_cpsr;
    o.err = e;
    expected_q.push_back(o);
  endtask

  // valid stays high between back-to-back items; it drops only while idling
  task automatic send_op(input func_e fn, input logic [3:0] r, input logic [31:0] d,
                         input logic [31:0] um = '1, input logic [31:0] pm = '1,
                         input logic [31:0] sm = '0, input logic [31:0] spm = '1,
                         input logic [2:0] kind = '0);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    reg_index_i <= r;
    data_i <= d;
    user_mask_i <= um;
    priv_mask_i <= pm;
    state_bits_mask_i <= sm;
    spsr_mask_i <= spm;
    exc_kind_i <= kind;
    do @(posedge clk_i); while (in_stall_o);
    predict_mode_op(fn, r, d, um, pm, sm, spm, kind);
  endtask

  // waits for the block to drain, then writes one register
  task automatic write_cfg(input cfg_e idx, input logic [31:0] v);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CTRL: m_ctrl = v;
      CFG_LEVEL: m_level = v[1:0];
      default: m_thumb = v[0];
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        exp_o = expected_q.pop_front();
        if (exp_o.rd !== read_data_o || exp_o.status !== status_word_o ||
            exp_o.pc !== target_pc_o || exp_o.err !== error_code_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rd %h st %h pc %h err %0d, got %h %h %h %0d",
                     exp_o.rd, exp_o.status, exp_o.pc, exp_o.err,
                     read_data_o, status_word_o, target_pc_o, error_code_o);
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i)
    out_stall_i <= hold_recv || (recv_idle > 0 && $urandom_range(99) < recv_idle);

  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_status();
    logic [4:0] modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT,
                              MODE_UND, MODE_SYS};
    logic [31:0] w;
    w = $urandom;
    w[BIT_E] = ($urandom_range(7) == 0);
    w[BIT_T] = ($urandom_range(3) == 0);
    if ($urandom_range(9) != 0) w[4:0] = modes[$urandom_range(6)];
    return w;
  endfunction

  task automatic test_directed();
    send_op(FN_RD_SPSR, 0, 0);
    send_op(FN_WR_SPSR, 0, 32'hFFFF_FFFF);
    send_op(FN_NZCV, 0, 32'hF000_0000);
    for (int k = 0; k < 8; k++) send_op(FN_EXC, 0, 32'hFFFF_FFFC, '1, '1, '0, '1, k);
    send_op(FN_WR_USR, 13, 32'hFFFF_FFFF);
    send_op(FN_RD_USR, 14, 0);
    send_op(FN_RET, 0, 32'hFFFF_FFFF);
    send_op(FN_WR_CPSR, 0, {27'h0, MODE_FIQ}, '1, 32'h1F, 32'h20);
    send_op(FN_WR_CPSR, 0, 32'h0000_0200, '1, 32'h200);
    send_op(FN_WR_CPSR, 0, 32'h0000_0011, '1, '1);
    send_op(FN_WR_USR, 8, 32'hA5A5_A5A5);
    send_op(FN_RD_USR, 8, 0);
    send_op(FN_WR_CPSR, 0, 32'h0000_000E, '1, 32'h1F);
    send_op(FN_WR_CPSR, 0, 32'h0000_0010, '1, 32'h1F);
    send_op(FN_RD_SPSR, 0, 0);
    send_op(FN_RET, 0, 0);
    send_op(FN_WR_CPSR, 0, 32'h0000_01DF, 32'hFFFF_FFFF, '1);
    in_valid_i <= 1'b0;
  endtask

  task automatic test_random(input int n);
    func_e fn;
    logic [31:0] sm;
    for (int i = 0; i < n; i++) begin
      fn = func_e'($urandom_range(7));
      sm = ($urandom_range(3) == 0) ? $urandom : 32'h0;
      case (fn)
        FN_WR_CPSR: send_op(fn, $urandom, pick_status(), pick_word(), pick_word(), sm);
        FN_WR_SPSR: send_op(fn, $urandom, pick_status(), '1, '1, '0, pick_word());
        FN_EXC: send_op(fn, $urandom, $urandom, '1, '1, '0, '1,
                        ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4));
        default: send_op(fn, $urandom, $urandom);
      endcase
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    m_ctrl = '0;
    m_level = 2;
    m_thumb = 1'b1;
    foreach (m_regs[i]) m_regs[i] = '0;
    foreach (m_sp[i]) begin
      m_sp[i] = '0;
      m_lr[i] = '0;
    end
    foreach (m_fiq[i]) begin
      m_fiq[i] = '0;
      m_spsr[i] = '0;
    end
    m_cpsr = CPSR_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle = 26;
    recv_idle = 88;
    write_cfg(CFG_CTRL, 32'hFFFF_FFFF);
    write_cfg(CFG_THUMB, 0);
    test_random(300);
    write_cfg(CFG_LEVEL, 0);
    test_random(150);
    send_idle = 88;
    recv_idle = 26;
    write_cfg(CFG_LEVEL, 1);
    write_cfg(CFG_THUMB, 1);
    write_cfg(CFG_CTRL, 32'h4A00_2000);
    test_random(300);
    send_idle = 0;
    recv_idle = 0;
    write_cfg(CFG_LEVEL, 3);
    write_cfg(CFG_CTRL, 32'h0);
    test_backpressure();
    write_cfg(CFG_LEVEL, 2);
    write_cfg(CFG_CTRL, $urandom);
    test_random(460);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("banked_register_file_mode_unit_test OK");
    else $display("banked_register_file_mode_unit_test NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("banked_register_file_mode_unit_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// File: banked_register_file_mode_unit.f
hw/rtl/brfmu_pkg.sv
hw/rtl/brfmu_ctrl.sv
hw/rtl/brfmu_dpath.sv
hw/rtl/banked_register_file_mode_unit.sv
dv/banked_register_file_mode_unit_test.sv
